// File: hdl/bba_pkg.sv
// ----------------------------------------------------------------------------
// Block bitmap allocator package
// Shared payload types, command and status groups and operation codes.
// ----------------------------------------------------------------------------
package bba_pkg;

    // Map words hold eight blocks each.
    localparam int WORD_BITS = 8;
    localparam int WORD_LSB  = 3;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [11:0] block_index;
        logic [12:0] block_count;
    } t_req;

    typedef struct packed {
        logic [11:0] start_index;
        logic        taken;
        logic        status;
    } t_rsp;

    // Controller to datapath.
    typedef struct packed {
        logic clear;
        logic load;
        logic setup;
        logic rd_en;
        logic advance;
        logic finish;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic clear_done;
        logic work;
        logic query_ok;
        logic at_end;
        logic out_free;
    } t_sts;

endpackage

// File: hdl/block_bitmap_allocator_unit.sv
// ----------------------------------------------------------------------------
// Block bitmap allocator unit
// Free-space usage map with a bump pointer: allocate, release and query.
// ----------------------------------------------------------------------------
// Usage: requests arrive as transactions on the input channel (i_in_valid,
// o_in_ready, i_in_data) and each produces exactly one response transaction
// on the output channel (o_out_valid, i_out_ready, o_out_data).
// The map lives in a memory of eight-block words. After reset a clearing
// sweep writes every word to zero, one word per cycle, covering
// ceil(NUM_BLOCKS / 8) words (512 at the default size); o_in_ready stays low
// until it finishes. The bump pointer resets to zero.
// One request is processed at a time. A run that touches W map words is
// walked by the single read port, one word per cycle, with the modified word
// written back in the cycle after its read. After set-up and routing, a walk
// ends in a drain state, a query reads its word and waits, and a rejected,
// empty or unknown request goes straight to finish, then the next is accepted.
// A response waits in the output register while the receiver stalls; the
// next request is still accepted and worked on, and its response is held
// back until the register has been emptied.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_unit #(
    parameter int NUM_BLOCKS = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bba_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bba_pkg::t_rsp o_out_data
);

    bba_pkg::t_cmd s_cmd;
    bba_pkg::t_sts s_sts;

    // The controller owns sequencing; the datapath owns all data state and memory.
    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd)
    );

    bba_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (s_cmd),
        .o_sts       (s_sts),
        .i_req       (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_rsp       (o_out_data)
    );

    // A rejected response never carries a start index or a taken flag.
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status |->
            (o_out_data.start_index == '0) && !o_out_data.taken)
        else $error("rejected response carries payload");

    // Only one request is in flight: no acceptance in the cycle after one.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted while another is in flight");

    // The clearing sweep and the map walk never share the memory.
    a_clear_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.clear |-> !s_cmd.rd_en && !o_in_ready)
        else $error("map access during clearing sweep");

    // A response is only loaded when the output register is free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.finish |-> !o_out_valid || i_out_ready)
        else $error("pending response overwritten");

endmodule

// File: hdl/bba_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/bba_ctrl.sv
// ----------------------------------------------------------------------------
// Block bitmap allocator controller
// Sequences the clearing sweep, request set-up, the word walk and the result.
// ----------------------------------------------------------------------------
module bba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bba_pkg::t_sts i_sts,
    output bba_pkg::t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_SETUP  = 8'b0000_0100,
        S_ROUTE  = 8'b0000_1000,
        S_READ   = 8'b0001_0000,
        S_DRAIN  = 8'b0010_0000,
        S_QREAD  = 8'b0100_0000,
        S_QWAIT  = 8'b1000_0000
    } t_state;

    // The finish step shares the idle code space through a dedicated flag.
    t_state r_state, n_state;
    logic   r_finish, n_finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_finish <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_finish <= n_finish;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_finish   = r_finish;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (r_finish) begin
                    // Hand the result over once the output register is free.
                    if (i_sts.out_free) begin
                        o_cmd.finish = 1'b1;
                        n_finish     = 1'b0;
                    end
                end else begin
                    o_in_ready = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_ROUTE;
            end
            S_ROUTE: begin
                if (i_sts.work) begin
                    n_state = S_READ;
                end else if (i_sts.query_ok) begin
                    n_state = S_QREAD;
                end else begin
                    n_state  = S_IDLE;
                    n_finish = 1'b1;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                if (i_sts.at_end) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            S_DRAIN: begin
                n_state  = S_IDLE;
                n_finish = 1'b1;
            end
            S_QREAD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_QWAIT;
            end
            S_QWAIT: begin
                n_state  = S_IDLE;
                n_finish = 1'b1;
            end
            default: begin
                n_state  = S_CLEAR;
                n_finish = 1'b0;
            end
        endcase
    end

endmodule

// File: hdl/bba_datapath.sv
// ----------------------------------------------------------------------------
// Block bitmap allocator datapath
// Request registers, range checks, map memory walk and the output register.
// ----------------------------------------------------------------------------
module bba_datapath #(
    parameter int NUM_BLOCKS = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bba_pkg::t_cmd i_cmd,
    output bba_pkg::t_sts o_sts,
    input  bba_pkg::t_req i_req,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output bba_pkg::t_rsp o_rsp
);

    localparam int POS_W = $clog2(NUM_BLOCKS);
    localparam int NF_W  = $clog2(NUM_BLOCKS + 1);
    localparam int DEPTH = (NUM_BLOCKS + bba_pkg::WORD_BITS - 1) / bba_pkg::WORD_BITS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W = ((POS_W + 1 > 13) ? POS_W + 1 : 13) + 1;
    localparam int LW    = bba_pkg::WORD_LSB;
    localparam int WB    = bba_pkg::WORD_BITS;

    bba_pkg::t_req r_req;
    bba_pkg::t_rsp r_out;
    logic [NF_W-1:0]  r_next_free, r_nf_after;
    logic [AW-1:0]    r_clr_addr, r_first_addr, r_end_addr, r_addr, r_pend_addr;
    logic [LW-1:0]    r_first_lo, r_last_lo;
    logic             r_reject, r_work, r_qok, r_commit, r_is_alloc;
    logic [11:0]      r_start;
    logic             r_pend_valid, r_taken, r_out_valid;

    // Set-up arithmetic on the registered request.
    logic             is_alloc, is_release, is_query, reject;
    logic [SUM_W-1:0] base_w, end_w, last_w, lim_w;
    logic [POS_W-1:0] first_pos, last_pos, first_sh, last_sh;

    always_comb begin
        is_alloc   = (r_req.operation == bba_pkg::OP_ALLOC);
        is_release = (r_req.operation == bba_pkg::OP_RELEASE);
        is_query   = (r_req.operation == bba_pkg::OP_QUERY);
        base_w     = is_alloc ? SUM_W'(r_next_free) : SUM_W'(r_req.block_index);
        end_w      = base_w + SUM_W'(r_req.block_count);
        last_w     = end_w - SUM_W'(1);
        lim_w      = SUM_W'(NUM_BLOCKS);
        if (is_alloc || is_release) begin
            reject = (end_w > lim_w);
        end else if (is_query) begin
            reject = (base_w >= lim_w);
        end else begin
            reject = 1'b0;
        end
        first_pos = base_w[POS_W-1:0];
        last_pos  = last_w[POS_W-1:0];
        first_sh  = first_pos >> LW;
        last_sh   = last_pos >> LW;
    end

    // Bit mask of the run within the word coming back from the memory.
    logic [LW-1:0] lo, hi;
    logic [WB-1:0] mask, rdata, wdata, mod_data;
    logic [AW-1:0] waddr;
    logic          we;

    always_comb begin
        lo = (r_pend_addr == r_first_addr) ? r_first_lo : '0;
        hi = (r_pend_addr == r_end_addr) ? r_last_lo : LW'(WB - 1);
        for (int b = 0; b < WB; b++) begin
            mask[b] = (LW'(b) >= lo) && (LW'(b) <= hi);
        end
        mod_data = r_is_alloc ? (rdata | mask) : (rdata & ~mask);
        we       = i_cmd.clear || (r_pend_valid && r_work);
        waddr    = i_cmd.clear ? r_clr_addr : r_pend_addr;
        wdata    = i_cmd.clear ? '0 : mod_data;
    end

    bba_ram #(
        .WIDTH (WB),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr   <= '0;
            r_next_free  <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_pend_valid <= i_cmd.rd_en;
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.finish && r_commit) begin
                r_next_free <= r_nf_after;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.setup) begin
            r_reject     <= reject;
            r_is_alloc   <= is_alloc;
            r_commit     <= is_alloc && !reject;
            r_work       <= (is_alloc || is_release) && !reject && (r_req.block_count != '0);
            r_qok        <= is_query && !reject;
            r_start      <= (is_alloc && !reject) ? base_w[11:0] : '0;
            r_nf_after   <= end_w[NF_W-1:0];
            r_first_lo   <= first_pos[LW-1:0];
            r_last_lo    <= last_pos[LW-1:0];
            r_first_addr <= first_sh[AW-1:0];
            r_addr       <= first_sh[AW-1:0];
            r_end_addr   <= last_sh[AW-1:0];
        end else if (i_cmd.advance) begin
            r_addr <= r_addr + 1'b1;
        end
        if (i_cmd.rd_en) begin
            r_pend_addr <= r_addr;
        end
        if (r_pend_valid && r_qok) begin
            r_taken <= rdata[r_first_lo];
        end
        if (i_cmd.finish) begin
            r_out.start_index <= r_start;
            r_out.taken       <= r_qok && r_taken;
            r_out.status      <= r_reject;
        end
    end

    always_comb begin
        o_sts.clear_done = (r_clr_addr == AW'(DEPTH - 1));
        o_sts.work       = r_work;
        o_sts.query_ok   = r_qok;
        o_sts.at_end     = (r_addr == r_end_addr);
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule
